[design/unique_entry_queue_defines.svh]
// Assertion macros used by the queue design file.
`ifndef UNIQUE_ENTRY_QUEUE_DEFINES_SVH
`define UNIQUE_ENTRY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define UEQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unique_entry_queue: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define UEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unique_entry_queue: next-cycle check failed");

`endif

[design/uniq_pkg.sv]
`timescale 1ns / 1ps

package uniq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_ADD    = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_ADDED     = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] removed_value;
        logic [4:0]         entry_count;
    } out_t;

    // Per-cell command for one cycle.
    typedef struct packed {
        logic load;
        logic shift;
        logic add;
    } cell_cmd_t;

endpackage

[design/unique_entry_queue.sv]
`timescale 1ns / 1ps

// Deduplicating first-in first-out queue of signed words.
//
// A command is transferred at a rising edge where start is high and busy is
// low. Its payload is request: an operation (insert, remove oldest, or add
// each entry's older neighbor into it) and the value to insert. Every command
// finishes without a stall, so busy stays low and a new command may follow on
// every edge: throughput is one command per cycle.
//
// The result transfer appears in the cycle after the command: done is high for
// exactly one cycle while result carries the status, the removed value (zero
// unless an entry was removed) and the entry count after the command. The
// receiver cannot stall, so it must take result whenever done is high.
//
// Storage is a row of identical cells, one per entry, oldest in cell zero.
// Each cell compares its word with the insert key, loads the key, takes its
// newer neighbor's word on a remove, or adds its older neighbor's word on a
// neighbor-add, all in the same cycle. The clock period is set by the
// key compare plus the OR over all cells' match bits.
// Reset empties the queue and drops done; cell contents are not cleared and
// are only read below the entry count.

`include "unique_entry_queue_defines.svh"

module unique_entry_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  uniq_pkg::in_t  request,
    output logic           done,
    output uniq_pkg::out_t result
);
    import uniq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  done_reg;
    out_t                  result_reg;
    out_t                  result_next;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]      match;
    logic [DEPTH-1:0]      occupied;
    cell_cmd_t             cmd [DEPTH];

    logic [DATA_WIDTH+31:0] key_ext;
    logic [DATA_WIDTH-1:0]  key;
    logic [DATA_WIDTH+31:0] removed_ext;
    logic [CNT_W+4:0]       count_ext;

    logic is_insert;
    logic is_remove;
    logic is_add;
    logic duplicate;
    logic full;
    logic insert_ok;
    logic remove_ok;

    // Every command completes in the cycle it is accepted.
    assign busy = 1'b0;

    // The 32-bit request value is sign-extended, then kept in the cell width.
    assign key_ext = {{DATA_WIDTH{request.value[31]}}, request.value};
    assign key     = key_ext[DATA_WIDTH-1:0];

    always_comb
    begin
        is_insert = 1'b0;
        is_remove = 1'b0;
        is_add    = 1'b0;
        unique case (request.operation)
            OP_INSERT: is_insert = 1'b1;
            OP_REMOVE: is_remove = 1'b1;
            default:   is_add    = 1'b1;  // The unused code acts as a neighbor-add.
        endcase
    end

    assign duplicate = |match;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign insert_ok = start && is_insert && !duplicate && !full;
    assign remove_ok = start && is_remove && (count_reg != '0);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] older;
            logic [DATA_WIDTH-1:0] newer;

            assign occupied[gi]  = (count_reg > CNT_W'(gi));
            assign cmd[gi].load  = insert_ok && (count_reg == CNT_W'(gi));
            assign cmd[gi].shift = remove_ok;
            assign cmd[gi].add   = start && is_add;

            // The oldest cell adds zero; the newest cell keeps its word on a remove.
            if (gi == 0)
            begin : g_first
                assign older = '0;
            end
            else
            begin : g_mid_old
                assign older = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign newer = cell_data[gi];
            end
            else
            begin : g_mid_new
                assign newer = cell_data[gi+1];
            end

            uniq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd[gi]),
                .occupied   (occupied[gi]),
                .key        (key),
                .older_data (older),
                .newer_data (newer),
                .data       (cell_data[gi]),
                .match      (match[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (insert_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (remove_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign removed_ext = {32'b0, cell_data[0]};
    assign count_ext   = {5'b0, count_next};

    always_comb
    begin
        result_next.removed_value = '0;
        result_next.entry_count   = count_ext[4:0];
        if (is_insert)
        begin
            priority if (duplicate)
            begin
                result_next.status = ST_DUPLICATE;
            end
            else if (full)
            begin
                result_next.status = ST_FULL;
            end
            else
            begin
                result_next.status = ST_INSERTED;
            end
        end
        else if (is_remove)
        begin
            if (count_reg == '0)
            begin
                result_next.status = ST_EMPTY;
            end
            else
            begin
                result_next.status        = ST_REMOVED;
                result_next.removed_value = removed_ext[31:0];
            end
        end
        else
        begin
            result_next.status = ST_ADDED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `UEQ_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `UEQ_ASSERT_NEXT(a_done_follows, start, done_reg)
    `UEQ_ASSERT_NEXT(a_insert_grows, insert_ok, count_reg == $past(count_reg) + 1'b1)
    `UEQ_ASSERT_IMPL(a_removed_zero, done_reg && (result_reg.status != ST_REMOVED),
                     result_reg.removed_value == '0)
    `UEQ_ASSERT_NEXT(a_remove_shrinks, remove_ok, count_reg == $past(count_reg) - 1'b1)

endmodule

[design/uniq_cell.sv]
`timescale 1ns / 1ps

module uniq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  uniq_pkg::cell_cmd_t     cmd,
    input  logic                    occupied,
    input  logic [DATA_WIDTH-1:0]   key,
    input  logic [DATA_WIDTH-1:0]   older_data,
    input  logic [DATA_WIDTH-1:0]   newer_data,
    output logic [DATA_WIDTH-1:0]   data,
    output logic                    match
);
    import uniq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        priority if (cmd.load)
        begin
            data_next = key;
        end
        else if (cmd.shift)
        begin
            data_next = newer_data;
        end
        else if (cmd.add)
        begin
            data_next = data_reg + older_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = occupied && (data_reg == key);

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the deduplicating queue.
//
// Commands are queued by the stimulus process into a backlog. The driver
// presents the head of that backlog on the falling edge, and the monitor
// notes each command transfer on the rising edge. At that moment a
// predictor works out the result the block must return, and the result
// is stored until it is checked. Every result transfer that the block
// reports with done is compared field by field against the oldest
// stored result.
module tb_top;

    import uniq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int RANDOM_ITEMS = 1000;

    // Operation code 3 is left undefined by the package. The block decodes
    // it in the default branch, so this code must behave like a neighbor-add.
    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    // Flavors of random batch. Each one steers the queue toward a region
    // of its behavior.
    localparam int BATCH_FILL  = 0;
    localparam int BATCH_EMPTY = 1;
    localparam int BATCH_MIXED = 2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_t request = '0;
    logic done;
    out_t result;

    // Commands waiting to be transferred, in order.
    in_t command_backlog [$];
    // Results that the block still owes, oldest first.
    out_t awaited_outcomes [$];

    // Predicted contents of the queue. Word 0 is the oldest entry.
    logic [31:0] held_words [QUEUE_DEPTH];
    int held_count = 0;

    // A few fixed words that inserts reuse, so duplicates turn up often
    // even after the queue has been emptied.
    logic [31:0] value_pool [8];

    int sender_idle_pct = 0;
    int error_count = 0;

    unique_entry_queue #(
        .DEPTH(QUEUE_DEPTH),
        .DATA_WIDTH(32)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    always #5 clk = ~clk;

    // Runs one command against the predicted queue contents and returns
    // the result that the block has to produce for it.
    function automatic out_t apply_command(in_t cmd);
        out_t outcome;
        logic hit;
        outcome = '0;
        if (cmd.operation == OP_INSERT)
        begin
            // The duplicate search comes before the capacity check, so a
            // held value offered to a full queue is reported as a duplicate.
            hit = 1'b0;
            for (int i = 0; i < held_count; i++)
            begin
                if (held_words[i] == cmd.value)
                    hit = 1'b1;
            end
            if (hit)
                outcome.status = ST_DUPLICATE;
            else if (held_count >= QUEUE_DEPTH)
                outcome.status = ST_FULL;
            else
            begin
                held_words[held_count] = cmd.value;
                held_count++;
                outcome.status = ST_INSERTED;
            end
        end
        else if (cmd.operation == OP_REMOVE)
        begin
            if (held_count == 0)
                outcome.status = ST_EMPTY;
            else
            begin
                outcome.removed_value = held_words[0];
                for (int i = 1; i < held_count; i++)
                    held_words[i - 1] = held_words[i];
                held_count--;
                outcome.status = ST_REMOVED;
            end
        end
        else
        begin
            // Walking from the newest entry down keeps every addend at its
            // old value. The oldest entry is left alone and sums wrap.
            for (int i = held_count - 1; i >= 1; i--)
                held_words[i] = held_words[i] + held_words[i - 1];
            outcome.status = ST_ADDED;
        end
        outcome.entry_count = 5'(held_count);
        return outcome;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Driver. The command is changed only on the falling edge. A command
    // that the block has not yet taken because busy is high stays on the
    // bus unchanged; otherwise the sender may idle at random.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && busy)
            ;
        else if (command_backlog.size() == 0 || $urandom_range(99) < sender_idle_pct)
            start <= 1'b0;
        else
        begin
            start <= 1'b1;
            request <= command_backlog[0];
        end
    end

    // Monitor. A command transfer is predicted first, so that a result
    // that arrives in the same cycle as the next command is still matched
    // against the older expectation at the front of the store.
    always @(posedge clk)
    begin : monitor
        out_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                awaited_outcomes.push_back(apply_command(request));
                void'(command_backlog.pop_front());
            end
            if (done)
            begin
                if (awaited_outcomes.size() == 0)
                    report_mismatch("unexpected result", 32'(result), 32'd0);
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", 32'(result.status), 32'(want.status));
                    if (result.removed_value !== want.removed_value)
                        report_mismatch("removed_value", result.removed_value,
                            want.removed_value);
                    if (result.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(result.entry_count),
                            32'(want.entry_count));
                end
            end
        end
    end

    task automatic queue_command(logic [1:0] op, logic [31:0] word);
        in_t cmd;
        cmd.operation = op;
        cmd.value = word;
        command_backlog.push_back(cmd);
    endtask

    // Holds the sender back until every queued command has been
    // transferred and every result has come back.
    task automatic wait_until_idle();
        while (command_backlog.size() != 0 || awaited_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Picks a word to insert. Words that are already held and words from
    // the shared pool exercise the duplicate path; the extremes and fully
    // random words cover every bit and the wrap of the neighbor sums.
    function automatic logic [31:0] pick_insert_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35 && held_count > 0)
            return held_words[$urandom_range(held_count - 1)];
        else if (roll < 65)
            return value_pool[$urandom_range(7)];
        else if (roll < 75)
        begin
            case ($urandom_range(3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Queues one random batch. The mix of operations depends on the flavor:
    // filling batches push the queue into its full state, emptying batches
    // run it dry, and mixed batches do a bit of everything.
    task automatic queue_random_batch(int flavor, int length);
        int roll;
        int insert_pct;
        int remove_pct;
        case (flavor)
            BATCH_FILL:
            begin
                insert_pct = 80;
                remove_pct = 8;
            end
            BATCH_EMPTY:
            begin
                insert_pct = 20;
                remove_pct = 70;
            end
            default:
            begin
                insert_pct = 45;
                remove_pct = 30;
            end
        endcase
        for (int n = 0; n < length; n++)
        begin
            roll = $urandom_range(99);
            if (roll < insert_pct)
                queue_command(OP_INSERT, pick_insert_value());
            else if (roll < insert_pct + remove_pct)
                queue_command(OP_REMOVE, $urandom);
            else if (roll < 97)
                queue_command(OP_ADD, $urandom);
            else
                queue_command(OP_UNDEFINED, $urandom);
        end
    endtask

    initial
    begin : stimulus
        int issued;
        int length;
        for (int i = 0; i < 8; i++)
            value_pool[i] = $urandom;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening. An empty queue must refuse a remove and treat a
        // neighbor-add as a no-op, as must a queue with one entry. The most
        // negative and most positive words are inserted, a duplicate is
        // refused, and their sum comes to all ones on the undefined operation code.
        sender_idle_pct = 31;
        queue_command(OP_REMOVE, 32'hFFFF_FFFF);
        queue_command(OP_ADD, 32'h0000_0000);
        queue_command(OP_INSERT, 32'h8000_0000);
        queue_command(OP_ADD, 32'h5555_5555);
        queue_command(OP_INSERT, 32'h7FFF_FFFF);
        queue_command(OP_INSERT, 32'h8000_0000);
        queue_command(OP_UNDEFINED, 32'hAAAA_AAAA);
        queue_command(OP_REMOVE, 32'h0000_0000);
        // One entry (all ones) is left. Fill the queue up, then offer a new
        // word, which is refused as full, and a held one, which is refused
        // as a duplicate because that check takes priority.
        for (int i = 1; i < QUEUE_DEPTH; i++)
            queue_command(OP_INSERT, 32'(i));
        queue_command(OP_INSERT, 32'h1234_5678);
        queue_command(OP_INSERT, 32'hFFFF_FFFF);
        wait_until_idle();

        // Random part in three stretches: the sender idles often, then very
        // often, then never. Every batch ends with the sender held back
        // until all results are in, so gaps also land on an idle block.
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if (issued >= 2 * RANDOM_ITEMS / 3)
                sender_idle_pct = 0;
            else if (issued >= RANDOM_ITEMS / 3)
                sender_idle_pct = 57;
            else
                sender_idle_pct = 31;
            length = $urandom_range(40, 1);
            queue_random_batch($urandom_range(BATCH_MIXED), length);
            issued += length;
            wait_until_idle();
        end

        // The block answers in the cycle after a command; the extra wait
        // gives any stray result the chance to show up.
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("%0t ns: timeout with %0d results outstanding", $time,
            awaited_outcomes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
